[hw/rtl/tno_pkg.sv]
// Shared constants, reply descriptor type and reply byte table for the
// telnet option negotiator. No dependencies.
`default_nettype none
package tno_pkg;

  // telnet command bytes
  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;

  // option codes
  localparam logic [7:0] OPT_ECHO  = 8'd1;
  localparam logic [7:0] OPT_SGA   = 8'd3;
  localparam logic [7:0] OPT_TTYPE = 8'd24;
  localparam logic [7:0] TT_IS     = 8'd0;

  localparam logic [31:0] NAME_RST = 32'h414E5349;

  // burst kinds
  localparam logic [1:0] K_NONE   = 2'd0;
  localparam logic [1:0] K_PASS   = 2'd1;
  localparam logic [1:0] K_REPLY3 = 2'd2;
  localparam logic [1:0] K_TTYPE  = 2'd3;

  localparam int unsigned IDX_W = 4;
  localparam logic [IDX_W-1:0] LAST_PASS   = 4'd0;
  localparam logic [IDX_W-1:0] LAST_REPLY3 = 4'd2;
  localparam logic [IDX_W-1:0] LAST_TTYPE  = 4'd9;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;   // passed byte or option byte
    logic [7:0] rverb;  // verb sent in a three-byte reply
  } desc_t;

  function automatic logic [7:0] tt_byte(input logic [IDX_W-1:0] idx,
                                         input logic [31:0] name);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = B_IAC;
      4'd1:    b = B_SB;
      4'd2:    b = OPT_TTYPE;
      4'd3:    b = TT_IS;
      4'd4:    b = name[31:24];
      4'd5:    b = name[23:16];
      4'd6:    b = name[15:8];
      4'd7:    b = name[7:0];
      4'd8:    b = B_IAC;
      4'd9:    b = B_SE;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/tno_decode.sv]
// Command parser: phase/verb state and per-byte reply decision.
// Depends on tno_pkg.
`default_nettype none
module tno_decode
  import tno_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic [7:0] rx_byte,
  input  wire logic       chunk_end,
  output desc_t           desc
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_VERB = 2'd1;
  localparam logic [1:0] PH_OPT  = 2'd2;
  localparam logic [1:0] PH_SKIP = 2'd3;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] verb_r, verb_nxt;
  logic       end_sb;
  logic       opt_known;

  assign end_sb    = (rx_byte == B_SE) || chunk_end;
  assign opt_known = (rx_byte == OPT_ECHO) || (rx_byte == OPT_SGA) ||
                     (rx_byte == OPT_TTYPE);

  always_comb begin
    phase_nxt  = phase_r;
    verb_nxt   = verb_r;
    desc.kind  = K_NONE;
    desc.data  = rx_byte;
    desc.rverb = B_WONT;
    unique case (phase_r)
      PH_IDLE: begin
        if (rx_byte == B_IAC) begin
          phase_nxt = PH_VERB;
        end else begin
          desc.kind = K_PASS;
        end
      end
      PH_VERB: begin
        verb_nxt  = rx_byte;
        phase_nxt = PH_OPT;
      end
      PH_OPT: begin
        phase_nxt = PH_IDLE;
        priority if (verb_r == B_DO &&
                     (rx_byte == OPT_SGA || rx_byte == OPT_TTYPE)) begin
          desc.kind  = K_REPLY3;
          desc.rverb = B_WILL;
        end else if ((verb_r == B_WILL || verb_r == B_WONT) && opt_known) begin
          desc.kind  = K_REPLY3;
          desc.rverb = B_DO;
        end else if (verb_r == B_WILL || verb_r == B_WONT) begin
          desc.kind  = K_REPLY3;
          desc.rverb = B_DONT;
        end else if (verb_r == B_DO || verb_r == B_DONT) begin
          desc.kind  = K_REPLY3;
          desc.rverb = B_WONT;
        end else if (verb_r == B_SB) begin
          if (end_sb) begin
            desc.kind = K_TTYPE;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end else begin
          // unknown verb: dropped with its option byte
          desc.kind = K_NONE;
        end
      end
      PH_SKIP: begin
        if (end_sb) begin
          phase_nxt = PH_IDLE;
          desc.kind = K_TTYPE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      verb_r  <= 8'd0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      verb_r  <= verb_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/tno_emit.sv]
// Result register and burst sequencer: holds one reply descriptor and
// steps through its beats. Depends on tno_pkg.
`default_nettype none
module tno_emit
  import tno_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire desc_t       desc,
  input  wire logic [31:0] name,
  output logic             can_load,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_to_socket,
  output logic             out_last_of_run
);

  logic             busy_r, busy_nxt;
  logic [1:0]       kind_r;
  logic [7:0]       data_r;
  logic [7:0]       rverb_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] last_idx;
  logic             out_fire;
  logic             at_last;

  always_comb begin
    unique case (kind_r)
      K_PASS:   last_idx = LAST_PASS;
      K_REPLY3: last_idx = LAST_REPLY3;
      K_TTYPE:  last_idx = LAST_TTYPE;
      default:  last_idx = LAST_PASS;
    endcase
  end

  assign at_last  = (idx_r == last_idx);
  assign out_fire = busy_r && out_ready;
  assign can_load = !busy_r || (out_ready && at_last);

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (out_fire) begin
      if (at_last) begin
        busy_nxt = 1'b0;
      end
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= desc.kind;
      data_r  <= desc.data;
      rverb_r <= desc.rverb;
    end
  end

  always_comb begin
    out_to_socket = 1'b1;
    unique case (kind_r)
      K_PASS: begin
        out_byte      = data_r;
        out_to_socket = 1'b0;
      end
      K_REPLY3: begin
        if (idx_r == 4'd0) begin
          out_byte = B_IAC;
        end else if (idx_r == 4'd1) begin
          out_byte = rverb_r;
        end else begin
          out_byte = data_r;
        end
      end
      K_TTYPE: out_byte = tt_byte(idx_r, name);
      default: out_byte = data_r;
    endcase
  end

  assign out_valid       = busy_r;
  assign out_last_of_run = at_last;

endmodule
`default_nettype wire

[hw/rtl/telnet_option_negotiator.sv]
// Top level of the telnet option negotiator: config register, parser and
// burst sequencer. Depends on tno_pkg, tno_decode, tno_emit.
//
//   channel | ports                                         | dir
//   in      | in_valid in_ready in_rx_byte in_chunk_end      | sink
//   out     | out_valid out_ready out_byte out_to_socket      | source
//           |   out_last_of_run                               |
//   cfg     | cfg_wr_en cfg_wr_data (terminal name)           | sink
//
// One byte is taken per cycle while the sequencer is free; a byte that gives one result is
// sent as one beat, an option reply as three beats and a terminal-type reply as ten beats,
// paced by the burst sequencer's beat counter. The next byte is taken in the
// cycle the last beat of a burst leaves. Output stall holds in_ready low.
// Synchronous active-low reset returns to idle and restores the name "ANSI".
`default_nettype none
module telnet_option_negotiator
  import tno_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_chunk_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_to_socket,
  output logic             out_last_of_run,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data
);

  logic [31:0] name_r;
  logic        in_fire;
  logic        can_load;
  desc_t       desc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_r <= NAME_RST;
    end else if (cfg_wr_en) begin
      name_r <= cfg_wr_data;
    end
  end

  assign in_ready = can_load;
  assign in_fire  = in_valid && in_ready;

  tno_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .rx_byte   (in_rx_byte),
    .chunk_end (in_chunk_end),
    .desc      (desc)
  );

  tno_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (in_fire && (desc.kind != K_NONE)),
    .desc            (desc),
    .name            (name_r),
    .can_load        (can_load),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_to_socket   (out_to_socket),
    .out_last_of_run (out_last_of_run)
  );

`ifndef SYNTHESIS
  // a stalled beat must block new input
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // terminal bytes are single-beat runs
  a_pass_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_to_socket |-> out_last_of_run)
    else $error("terminal byte not last of run");

  // a burst continues until its last beat
  a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> out_valid && out_to_socket)
    else $error("reply burst broken");

  // an idle sequencer always takes input
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("idle but not ready");
`endif

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for telnet_option_negotiator: directed table plus random
// telnet streams, checked beat by beat against a local byte-level predictor.
// Depends on tno_pkg and the telnet_option_negotiator RTL.
`timescale 1ns / 100ps
module tb_top;
  import tno_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_PER_PHASE = 86;

  typedef enum logic [1:0] {
    PS_IDLE = 2'd0,
    PS_VERB = 2'd1,
    PS_OPT  = 2'd2,
    PS_SKIP = 2'd3
  } parse_t;

  // one input byte; fixed rows carry up to three typed-in result bytes
  typedef struct packed {
    logic [7:0]      rx;
    logic            ce;
    logic            fixed;
    logic [1:0]      nfix;
    logic [0:2][7:0] fx;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       sock;
    logic       last;
  } beat_t;

  localparam rx_item_t DIRECTED [0:24] = '{
    '{8'h00, 1'b0, 1'b1, 2'd1, {8'h00, 8'h00, 8'h00}},
    '{8'hFE, 1'b1, 1'b1, 2'd1, {8'hFE, 8'h00, 8'h00}},
    '{8'hFF, 1'b1, 1'b1, 2'd0, 24'h0},                    // command split over chunks
    '{8'hFD, 1'b1, 1'b1, 2'd0, 24'h0},
    '{8'h18, 1'b0, 1'b1, 2'd3, {8'hFF, 8'hFB, 8'h18}},    // DO ttype -> WILL
    '{8'hFF, 1'b0, 1'b1, 2'd0, 24'h0},
    '{8'hFB, 1'b0, 1'b1, 2'd0, 24'h0},
    '{8'h01, 1'b0, 1'b1, 2'd3, {8'hFF, 8'hFD, 8'h01}},    // WILL echo -> DO
    '{8'hFF, 1'b0, 1'b1, 2'd0, 24'h0},
    '{8'hFC, 1'b0, 1'b1, 2'd0, 24'h0},
    '{8'h00, 1'b0, 1'b1, 2'd3, {8'hFF, 8'hFE, 8'h00}},    // WONT other -> DONT
    '{8'hFF, 1'b0, 1'b1, 2'd0, 24'h0},
    '{8'hFE, 1'b0, 1'b1, 2'd0, 24'h0},
    '{8'hFF, 1'b0, 1'b1, 2'd3, {8'hFF, 8'hFC, 8'hFF}},    // DONT -> WONT
    '{8'hFF, 1'b0, 1'b0, 2'd0, 24'h0},
    '{8'hFA, 1'b0, 1'b0, 2'd0, 24'h0},
    '{8'hF0, 1'b0, 1'b0, 2'd0, 24'h0},                    // SB then SE at once
    '{8'hFF, 1'b0, 1'b0, 2'd0, 24'h0},
    '{8'hFA, 1'b0, 1'b0, 2'd0, 24'h0},
    '{8'h18, 1'b0, 1'b0, 2'd0, 24'h0},
    '{8'h09, 1'b1, 1'b0, 2'd0, 24'h0},                    // chunk end stops the skip
    '{8'hFF, 1'b0, 1'b1, 2'd0, 24'h0},
    '{8'hFF, 1'b0, 1'b1, 2'd0, 24'h0},                    // doubled IAC swallows next
    '{8'h07, 1'b0, 1'b1, 2'd0, 24'h0},
    '{8'h41, 1'b1, 1'b1, 2'd1, {8'h41, 8'h00, 8'h00}}
  };

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        in_chunk_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_to_socket;
  logic        out_last_of_run;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = 32'h0;

  telnet_option_negotiator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .in_chunk_end    (in_chunk_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_to_socket   (out_to_socket),
    .out_last_of_run (out_last_of_run),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor state
  parse_t      pstate = PS_IDLE;
  logic [7:0]  cmd_verb = 8'h00;
  logic [31:0] term_name = NAME_RST;

  rx_item_t stim_q[$];
  beat_t    beats_owed[$];
  rx_item_t on_wire;
  beat_t    want;
  int       mismatches = 0;
  int       cycles = 0;

  function automatic void owe(input logic [7:0] b, input logic sock);
    beats_owed.push_back('{b, sock, 1'b0});
  endfunction

  function automatic void owe_reply3(input logic [7:0] v, input logic [7:0] opt);
    owe(B_IAC, 1'b1);
    owe(v, 1'b1);
    owe(opt, 1'b1);
  endfunction

  function automatic void owe_ttype();
    owe(B_IAC, 1'b1);
    owe(B_SB, 1'b1);
    owe(OPT_TTYPE, 1'b1);
    owe(TT_IS, 1'b1);
    owe(term_name[31:24], 1'b1);
    owe(term_name[23:16], 1'b1);
    owe(term_name[15:8], 1'b1);
    owe(term_name[7:0], 1'b1);
    owe(B_IAC, 1'b1);
    owe(B_SE, 1'b1);
  endfunction

  // advance the parser by one received byte and queue the beats it owes
  function automatic void negotiate_byte(input logic [7:0] b, input logic ce);
    int base;
    logic will_wont;
    base = beats_owed.size();
    will_wont = (cmd_verb == B_WILL) || (cmd_verb == B_WONT);
    case (pstate)
      PS_IDLE: begin
        if (b == B_IAC) pstate = PS_VERB;
        else owe(b, 1'b0);
      end
      PS_VERB: begin
        cmd_verb = b;
        pstate = PS_OPT;
      end
      PS_OPT: begin
        pstate = PS_IDLE;
        if (cmd_verb == B_DO && (b == OPT_SGA || b == OPT_TTYPE)) begin
          owe_reply3(B_WILL, b);
        end else if (will_wont && (b == OPT_ECHO || b == OPT_SGA || b == OPT_TTYPE)) begin
          owe_reply3(B_DO, b);
        end else if (will_wont) begin
          owe_reply3(B_DONT, b);
        end else if (cmd_verb == B_DO || cmd_verb == B_DONT) begin
          owe_reply3(B_WONT, b);
        end else if (cmd_verb == B_SB) begin
          if (b == B_SE || ce) owe_ttype();
          else pstate = PS_SKIP;
        end
      end
      default: begin
        if (b == B_SE || ce) begin
          pstate = PS_IDLE;
          owe_ttype();
        end
      end
    endcase
    if (beats_owed.size() > base) beats_owed[beats_owed.size() - 1].last = 1'b1;
  endfunction

  function automatic void accept_byte(input rx_item_t it);
    int base;
    base = beats_owed.size();
    negotiate_byte(it.rx, it.ce);
    if (it.fixed) begin
      // typed-in rows replace the predicted beats, state still advances
      while (beats_owed.size() > base) void'(beats_owed.pop_back());
      for (int i = 0; i < it.nfix; i++)
        beats_owed.push_back('{it.fx[i], it.nfix == 2'd3, i == it.nfix - 1});
    end
  endfunction

  function automatic logic rand_ce();
    return $urandom_range(0, 7) == 0;
  endfunction

  function automatic void push_stim(input logic [7:0] rx, input logic ce);
    rx_item_t it;
    it = '0;
    it.rx = rx;
    it.ce = ce;
    stim_q.push_back(it);
  endfunction

  // mostly well-formed telnet traffic with random content, some noise
  task automatic queue_random(input int count);
    int made;
    int k;
    int nskip;
    logic [7:0] v;
    made = 0;
    while (made < count) begin
      k = $urandom_range(0, 99);
      if (k < 30) begin
        push_stim(8'($urandom_range(0, 254)), rand_ce());
        made++;
      end else if (k < 68) begin
        case ($urandom_range(0, 3))
          0: v = B_DO;
          1: v = B_DONT;
          2: v = B_WILL;
          default: v = B_WONT;
        endcase
        push_stim(B_IAC, rand_ce());
        push_stim(v, rand_ce());
        case ($urandom_range(0, 4))
          0: v = OPT_ECHO;
          1: v = OPT_SGA;
          2: v = OPT_TTYPE;
          default: v = 8'($urandom_range(0, 255));
        endcase
        push_stim(v, rand_ce());
        made += 3;
      end else if (k < 84) begin
        push_stim(B_IAC, rand_ce());
        push_stim(B_SB, rand_ce());
        push_stim(($urandom_range(0, 4) == 0) ? B_SE : OPT_TTYPE, rand_ce());
        nskip = $urandom_range(0, 4);
        for (int i = 0; i < nskip; i++) push_stim(8'($urandom_range(0, 255)), rand_ce());
        push_stim(B_SE, rand_ce());
        made += 4 + nskip;
      end else if (k < 92) begin
        push_stim(B_IAC, rand_ce());
        push_stim(($urandom_range(0, 2) == 0) ? B_IAC : 8'($urandom_range(0, 249)), rand_ce());
        push_stim(8'($urandom_range(0, 255)), rand_ce());
        made += 3;
      end else begin
        push_stim(8'($urandom_range(0, 255)), rand_ce());
        made++;
      end
    end
  endtask

  task automatic drain();
    while (stim_q.size() != 0 || in_valid || beats_owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_name(input logic [31:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    term_name = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // sender: bursts of beats with random gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (stim_q.size() > 0) begin
        rx_item_t nxt;
        nxt = stim_q.pop_front();
        on_wire <= nxt;
        in_rx_byte <= nxt.rx;
        in_chunk_end <= nxt.ce;
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches among four modes at random intervals
  int ready_mode = 0;
  int mode_left = 0;
  int tick = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      tick++;
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (tick % 4) != 3;
        default: out_ready <= $urandom_range(0, 3) == 0;
      endcase
    end
  end

  // predict on each accepted input beat, then check each accepted output beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) accept_byte(on_wire);
      if (out_valid && out_ready) begin
        if (beats_owed.size() == 0) begin
          $error("out_byte: no beat expected, actual %0d", out_byte);
          mismatches++;
        end else begin
          want = beats_owed.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %0d actual %0d", want.data, out_byte);
            mismatches++;
          end
          if (out_to_socket !== want.sock) begin
            $error("out_to_socket: expected %0d actual %0d", want.sock, out_to_socket);
            mismatches++;
          end
          if (out_last_of_run !== want.last) begin
            $error("out_last_of_run: expected %0d actual %0d", want.last, out_last_of_run);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] names [0:3];
    names[0] = 32'h0000_0000;
    names[1] = 32'hFFFF_FFFF;
    names[2] = $urandom();
    names[3] = NAME_RST;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // directed part runs on the reset name
    foreach (DIRECTED[i]) stim_q.push_back(DIRECTED[i]);
    drain();
    for (int p = 0; p < 4; p++) begin
      write_name(names[p]);
      queue_random(RANDOM_PER_PHASE);
      drain();
    end
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
